FILE: design/hcfm_pkg.sv
// Shared constants, payload types and unit command types of the crossing frequency meter.
package hcfm_pkg;

  localparam int SampleBits = 12;
  localparam int IndexBits  = 16;
  localparam int FracBits   = 16;
  localparam int LevelW     = 16;
  localparam int CountW     = 16;
  localparam int RateW      = 24;
  localparam int FreqW      = 32;
  localparam int ScaleBits  = 8;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 24;

  // Samples are compared in sixteenths of an LSB.
  localparam int SubW      = SampleBits + 4;
  localparam int ThrW      = ((SubW > LevelW) ? SubW : LevelW) + 1;
  localparam int PosW      = IndexBits + FracBits;
  localparam int ProdW     = CountW + RateW;
  localparam int DvdW      = ProdW + ScaleBits + FracBits;
  localparam int DsrW      = PosW;
  localparam int QuoW      = FreqW;
  localparam int StepW     = $clog2(DvdW + 1);
  localparam int MulStepW  = $clog2(CountW + 1);
  localparam int CrossSteps = SubW + FracBits;

  localparam logic [CfgIdxW-1:0] CfgMid  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHyst = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgRate = 2'd2;

  localparam logic [LevelW-1:0] MidReset  = 16'd32768;
  localparam logic [LevelW-1:0] HystReset = 16'd64;
  localparam logic [RateW-1:0]  RateReset = 24'd1000000;

  typedef struct packed {
    logic [SampleBits-1:0] sample;
    logic                  last;
  } in_item_t;

  typedef struct packed {
    logic [FreqW-1:0]  frequency_q8;
    logic [CountW-1:0] period_count;
    logic              valid_res;
  } out_item_t;

  typedef struct packed {
    logic             start;
    logic [StepW-1:0] steps;
    logic [DvdW-1:0]  dividend;
    logic [DsrW-1:0]  divisor;
  } div_cmd_t;

  typedef struct packed {
    logic            done;
    logic            ovf;
    logic [QuoW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic              start;
    logic [RateW-1:0]  mcand;
    logic [CountW-1:0] mplier;
  } mul_cmd_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] prod;
  } mul_rsp_t;

endpackage

FILE: design/hcfm_serial_div.sv
// Restoring divider that takes one dividend bit per cycle, MSB first.
module hcfm_serial_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcfm_pkg::div_cmd_t  cmd_i,
  output hcfm_pkg::div_rsp_t  rsp_o
);

  logic                        busy_q;
  logic                        done_q;
  logic [hcfm_pkg::StepW-1:0]  cnt_q;
  logic [hcfm_pkg::DvdW-1:0]   dvd_q;
  logic [hcfm_pkg::DsrW-1:0]   dsr_q;
  logic [hcfm_pkg::DsrW-1:0]   rem_q;
  logic [hcfm_pkg::QuoW-1:0]   quo_q;
  logic                        ovf_q;

  logic [hcfm_pkg::DsrW:0]     trial;
  logic [hcfm_pkg::DsrW:0]     diff;
  logic                        fits;
  logic [hcfm_pkg::DsrW-1:0]   rem_d;

  assign trial = {rem_q, dvd_q[hcfm_pkg::DvdW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};
  // When the trial fails it is below the divisor and fits the remainder width.
  assign rem_d = fits ? diff[hcfm_pkg::DsrW-1:0] : trial[hcfm_pkg::DsrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - hcfm_pkg::StepW'(1);
        if (cnt_q == hcfm_pkg::StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dvd_q <= cmd_i.dividend;
      dsr_q <= cmd_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[hcfm_pkg::DvdW-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[hcfm_pkg::QuoW-2:0], fits};
      // A set bit pushed out of the top means the quotient does not fit.
      ovf_q <= ovf_q | quo_q[hcfm_pkg::QuoW-1];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = quo_q;

endmodule

FILE: design/hcfm_serial_mul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
module hcfm_serial_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcfm_pkg::mul_cmd_t  cmd_i,
  output hcfm_pkg::mul_rsp_t  rsp_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [hcfm_pkg::MulStepW-1:0]  cnt_q;
  logic [hcfm_pkg::ProdW-1:0]     acc_q;
  logic [hcfm_pkg::RateW-1:0]     mc_q;
  logic [hcfm_pkg::RateW:0]       sum;

  assign sum = {1'b0, acc_q[hcfm_pkg::ProdW-1:hcfm_pkg::CountW]}
             + (acc_q[0] ? {1'b0, mc_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= hcfm_pkg::MulStepW'(hcfm_pkg::CountW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - hcfm_pkg::MulStepW'(1);
        if (cnt_q == hcfm_pkg::MulStepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= {{hcfm_pkg::RateW{1'b0}}, cmd_i.mplier};
      mc_q  <= cmd_i.mcand;
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[hcfm_pkg::CountW-1:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

endmodule

FILE: design/hysteresis_crossing_frequency_meter.sv
// Top level of the hysteresis crossing frequency meter: detector, sequencer and result register.
// A sample without a crossing is taken while the sequencer is idle; one with a rising crossing
// holds the input while the 32-step serial divider interpolates it.
// On the last sample of a capture the result follows 16 multiplier steps, 64 divider steps and
// the sequencer hops, after the interpolation first when that sample also crosses. The result
// register lets the next capture start while it waits.
// Reset loads the register defaults and clears the capture state at once; no clearing pass.
module hysteresis_crossing_frequency_meter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hcfm_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output hcfm_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [hcfm_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [hcfm_pkg::CfgDataW-1:0]     cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XDIV,
    ST_CHK,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic [hcfm_pkg::LevelW-1:0] mid_q;
  logic [hcfm_pkg::LevelW-1:0] hyst_q;
  logic [hcfm_pkg::RateW-1:0]  rate_q;

  // Capture state.
  logic [hcfm_pkg::SampleBits-1:0] prev_q;
  logic                            have_prev_q;
  logic                            armed_q;
  logic [hcfm_pkg::IndexBits-1:0]  index_q;
  logic [hcfm_pkg::IndexBits-1:0]  base_q;
  logic [hcfm_pkg::CountW-1:0]     count_q;
  logic [hcfm_pkg::PosW-1:0]       first_q;
  logic [hcfm_pkg::PosW-1:0]       last_q;
  logic                            pend_last_q;

  hcfm_pkg::out_item_t res_q;
  hcfm_pkg::out_item_t out_data_q;
  logic                out_valid_q;

  hcfm_pkg::div_cmd_t div_cmd;
  hcfm_pkg::div_rsp_t div_rsp;
  hcfm_pkg::mul_cmd_t mul_cmd;
  hcfm_pkg::mul_rsp_t mul_rsp;

  logic                        in_fire;
  logic                        out_free;
  logic [hcfm_pkg::SubW-1:0]   a16;
  logic [hcfm_pkg::SubW-1:0]   b16;
  logic [hcfm_pkg::ThrW-1:0]   a_ext;
  logic [hcfm_pkg::ThrW-1:0]   b_ext;
  logic [hcfm_pkg::ThrW-1:0]   mid_ext;
  logic [hcfm_pkg::ThrW-1:0]   hyst_ext;
  logic [hcfm_pkg::ThrW-1:0]   hi;
  logic [hcfm_pkg::ThrW-1:0]   rise;
  logic [hcfm_pkg::SubW-1:0]   span;
  logic                        below_lo;
  logic                        arm_now;
  logic                        cross_hit;
  logic                        valid_chk;
  logic [hcfm_pkg::PosW-1:0]   cross_pos;
  logic [hcfm_pkg::PosW-1:0]   delta;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Threshold tests in sixteenths of an LSB. The low threshold is tested as
  // a + hysteresis < mid so that a negative threshold simply never arms.
  assign a16      = {prev_q, 4'b0000};
  assign b16      = {in_data_i.sample, 4'b0000};
  assign a_ext    = hcfm_pkg::ThrW'(a16);
  assign b_ext    = hcfm_pkg::ThrW'(b16);
  assign mid_ext  = hcfm_pkg::ThrW'(mid_q);
  assign hyst_ext = hcfm_pkg::ThrW'(hyst_q);
  assign hi       = mid_ext + hyst_ext;
  assign below_lo = (a_ext + hyst_ext) < mid_ext;
  assign arm_now  = armed_q || below_lo;
  assign cross_hit = have_prev_q && arm_now && (a_ext < hi) && (b_ext >= hi);

  // On a crossing the rise to the threshold never exceeds the sample step, so both
  // fit the scaled sample width and the interpolated fraction is at most one.
  assign rise = hi - a_ext;
  assign span = b16 - a16;

  assign cross_pos = {base_q, {hcfm_pkg::FracBits{1'b0}}}
                   + hcfm_pkg::PosW'(div_rsp.quot[hcfm_pkg::FracBits:0]);

  assign valid_chk = (count_q >= hcfm_pkg::CountW'(2)) && (last_q > first_q);
  assign delta     = last_q - first_q;

  // The divider is shared: the interpolation of a crossing, started on the
  // accepting edge, and the final frequency division, started when the
  // product of periods and sample rate is ready.
  always_comb begin
    div_cmd.start = (in_fire && cross_hit) || ((state_q == ST_MUL) && mul_rsp.done);
    if (state_q == ST_IDLE) begin
      div_cmd.steps    = hcfm_pkg::StepW'(hcfm_pkg::CrossSteps);
      div_cmd.dividend = {rise[hcfm_pkg::SubW-1:0], {(hcfm_pkg::DvdW - hcfm_pkg::SubW){1'b0}}};
      div_cmd.divisor  = hcfm_pkg::DsrW'(span);
    end else begin
      div_cmd.steps    = hcfm_pkg::StepW'(hcfm_pkg::DvdW);
      div_cmd.dividend = {mul_rsp.prod, {(hcfm_pkg::ScaleBits + hcfm_pkg::FracBits){1'b0}}};
      div_cmd.divisor  = delta;
    end
  end

  assign mul_cmd.start  = (state_q == ST_CHK) && valid_chk;
  assign mul_cmd.mcand  = rate_q;
  assign mul_cmd.mplier = count_q - hcfm_pkg::CountW'(1);

  hcfm_serial_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .rsp_o  (div_rsp)
  );

  hcfm_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .rsp_o  (mul_rsp)
  );

  // Register writes; an index past the list is accepted and ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q  <= hcfm_pkg::MidReset;
      hyst_q <= hcfm_pkg::HystReset;
      rate_q <= hcfm_pkg::RateReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        hcfm_pkg::CfgMid:  mid_q  <= cfg_data_i[hcfm_pkg::LevelW-1:0];
        hcfm_pkg::CfgHyst: hyst_q <= cfg_data_i[hcfm_pkg::LevelW-1:0];
        hcfm_pkg::CfgRate: rate_q <= cfg_data_i[hcfm_pkg::RateW-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer with the capture state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_q      <= '0;
      have_prev_q <= 1'b0;
      armed_q     <= 1'b0;
      index_q     <= '0;
      base_q      <= '0;
      count_q     <= '0;
      first_q     <= '0;
      last_q      <= '0;
      pend_last_q <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // In the output state the result register is reloaded below instead.
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            prev_q      <= in_data_i.sample;
            have_prev_q <= 1'b1;
            index_q     <= index_q + hcfm_pkg::IndexBits'(1);
            // The previous sample of this request sits one index back.
            base_q      <= index_q - hcfm_pkg::IndexBits'(1);
            pend_last_q <= in_data_i.last;
            if (have_prev_q) begin
              armed_q <= cross_hit ? 1'b0 : arm_now;
            end
            if (cross_hit) begin
              state_q <= ST_XDIV;
            end else if (in_data_i.last) begin
              state_q <= ST_CHK;
            end
          end
        end
        ST_XDIV: begin
          if (div_rsp.done) begin
            if (count_q == '0) begin
              first_q <= cross_pos;
            end
            last_q <= cross_pos;
            // The crossing count saturates at its full scale.
            if (count_q != '1) begin
              count_q <= count_q + hcfm_pkg::CountW'(1);
            end
            state_q <= pend_last_q ? ST_CHK : ST_IDLE;
          end
        end
        ST_CHK: begin
          if (valid_chk) begin
            state_q <= ST_MUL;
          end else begin
            res_q   <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_MUL: begin
          if (mul_rsp.done) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            res_q.frequency_q8 <= div_rsp.ovf ? '1 : div_rsp.quot;
            res_q.period_count <= count_q - hcfm_pkg::CountW'(1);
            res_q.valid_res    <= 1'b1;
            state_q            <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_data_q  <= res_q;
            out_valid_q <= 1'b1;
            prev_q      <= '0;
            have_prev_q <= 1'b0;
            armed_q     <= 1'b0;
            index_q     <= '0;
            count_q     <= '0;
            first_q     <= '0;
            last_q      <= '0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // An invalid result carries zero in its other fields.
  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.valid_res |->
      (out_data_o.frequency_q8 == '0) && (out_data_o.period_count == '0))
    else $error("invalid result with nonzero fields");

  // A valid result spans at least one full period.
  a_valid_period : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.valid_res |-> (out_data_o.period_count != '0))
    else $error("valid result with zero periods");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> ((state_q == ST_XDIV) || (state_q == ST_DIV)))
    else $error("divider finished outside a divide state");

  // The multiplier finishes only in its own state, and the divider starts on that edge.
  a_mul_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == ST_MUL) ##1 (state_q == ST_DIV))
    else $error("multiplier finished outside its state");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the hysteresis crossing frequency meter, with its scoreboard class.
`timescale 1ns / 1ps

module testbench;

  // Index 3 is not a register: a write there must leave every setting alone.
  localparam logic [hcfm_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;

  localparam int RandomItems = 1870;
  localparam int QuietTail   = 1600;  // phases that start after this many random items do not idle
  localparam int LongHold    = 600;   // receiver hold-off that fills the block up
  localparam int DrainCycles = 200;   // well past the result latency

  // The scoreboard keeps its own copy of the registers and of the capture state.
  // Every accepted request is run through the same detector and divider arithmetic,
  // and a capture's final sample queues the reading the block must return.
  class meter_scoreboard;
    logic [hcfm_pkg::LevelW-1:0]     mid_q4;
    logic [hcfm_pkg::LevelW-1:0]     hyst_q4;
    logic [hcfm_pkg::RateW-1:0]      rate_hz;
    logic [hcfm_pkg::SampleBits-1:0] prev_sample;
    bit                              have_prev;
    bit                              armed;
    logic [hcfm_pkg::IndexBits-1:0]  sample_idx;
    logic [hcfm_pkg::CountW-1:0]     crossings;
    logic [hcfm_pkg::PosW-1:0]       first_pos;
    logic [hcfm_pkg::PosW-1:0]       last_pos;
    hcfm_pkg::out_item_t             expected_readings[$];
    int                              errors;

    function new();
      mid_q4  = hcfm_pkg::MidReset;
      hyst_q4 = hcfm_pkg::HystReset;
      rate_hz = hcfm_pkg::RateReset;
      errors  = 0;
      clear_capture();
    endfunction

    function void clear_capture();
      prev_sample = '0;
      have_prev   = 1'b0;
      armed       = 1'b0;
      sample_idx  = '0;
      crossings   = '0;
      first_pos   = '0;
      last_pos    = '0;
    endfunction

    function void write_reg(logic [hcfm_pkg::CfgIdxW-1:0] idx,
                            logic [hcfm_pkg::CfgDataW-1:0] data);
      case (idx)
        hcfm_pkg::CfgMid:  mid_q4  = data[hcfm_pkg::LevelW-1:0];
        hcfm_pkg::CfgHyst: hyst_q4 = data[hcfm_pkg::LevelW-1:0];
        hcfm_pkg::CfgRate: rate_hz = data[hcfm_pkg::RateW-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(hcfm_pkg::in_item_t item);
      longint                         lo;
      longint                         hi;
      longint                         a16;
      longint                         b16;
      logic [63:0]                    frac;
      logic [hcfm_pkg::IndexBits-1:0] a_idx;
      logic [hcfm_pkg::PosW-1:0]      pos;
      logic [127:0]                   scaled;
      logic [127:0]                   quo;
      hcfm_pkg::out_item_t            reading;
      if (have_prev) begin
        // Thresholds are compared in sixteenths of an LSB without wrapping.
        lo  = longint'(mid_q4) - longint'(hyst_q4);
        hi  = longint'(mid_q4) + longint'(hyst_q4);
        a16 = longint'(prev_sample) * 16;
        b16 = longint'(item.sample) * 16;
        if (a16 < lo) begin
          armed = 1'b1;
        end
        if (armed && a16 < hi && b16 >= hi) begin
          // Linear interpolation between the two samples, truncated.
          frac  = (64'(hi - a16) << hcfm_pkg::FracBits) / 64'(b16 - a16);
          a_idx = sample_idx - 1'b1;
          pos   = hcfm_pkg::PosW'((64'(a_idx) << hcfm_pkg::FracBits) + frac);
          if (crossings == '0) begin
            first_pos = pos;
          end
          last_pos = pos;
          if (crossings != '1) begin
            crossings++;
          end
          armed = 1'b0;
        end
      end
      prev_sample = item.sample;
      have_prev   = 1'b1;
      sample_idx++;
      if (item.last) begin
        reading = '0;
        if (crossings >= 2 && last_pos > first_pos) begin
          // Saturating after the full quotient matches a serial divider that
          // saturates as soon as it overflows, since the quotient only grows.
          scaled = (128'(crossings) - 128'd1) * 128'(rate_hz);
          quo    = (scaled << (hcfm_pkg::ScaleBits + hcfm_pkg::FracBits))
                 / 128'(last_pos - first_pos);
          reading.frequency_q8 = (quo > 128'hFFFF_FFFF) ? '1 : quo[hcfm_pkg::FreqW-1:0];
          reading.period_count = crossings - 1'b1;
          reading.valid_res    = 1'b1;
        end
        expected_readings.push_back(reading);
        clear_capture();
      end
    endfunction

    function void compare_field(string field, logic [hcfm_pkg::FreqW-1:0] want,
                                logic [hcfm_pkg::FreqW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      end
    endfunction

    function void check_result(hcfm_pkg::out_item_t got);
      hcfm_pkg::out_item_t want;
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t: unexpected reading, expected none, actual %h", $time, got);
        return;
      end
      want = expected_readings.pop_front();
      compare_field("frequency_q8", want.frequency_q8, got.frequency_q8);
      compare_field("period_count", hcfm_pkg::FreqW'(want.period_count),
                    hcfm_pkg::FreqW'(got.period_count));
      compare_field("valid_res", hcfm_pkg::FreqW'(want.valid_res),
                    hcfm_pkg::FreqW'(got.valid_res));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  hcfm_pkg::in_item_t            in_data_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  hcfm_pkg::out_item_t           out_data_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [hcfm_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [hcfm_pkg::CfgDataW-1:0] cfg_data_i;

  meter_scoreboard sb = new();

  // Random idling on both sides is switched per phase; the receiver also honors
  // a one-off long hold-off request from the stimulus process.
  bit idle_on;
  int rx_hold_len;
  int items_sent;

  hysteresis_crossing_frequency_meter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Inputs move on the falling edge, so sampling at the rising edge sees settled
  // values. The result is checked before the request is noted, although the two
  // can never belong to each other within one edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_result(out_data_o);
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_sample(in_data_i);
      end
    end
  end

  // Result side: ready is high unless a random stall burst or the long hold-off
  // is in progress. Ready is written once per falling edge at most.
  initial begin
    int stall;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_len != 0) begin
        stall = rx_hold_len;
        rx_hold_len = 0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 18);
      end else begin
        stall = 0;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Offers one sample request and returns at the falling edge after it was taken.
  // Valid stays high into the next call unless that call opens a gap.
  task automatic send_sample(input logic [hcfm_pkg::SampleBits-1:0] value, input bit is_last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample: value, last: is_last};
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_burst(input int values[$]);
    foreach (values[i]) begin
      send_sample(hcfm_pkg::SampleBits'(values[i]), i == values.size() - 1);
    end
  endtask

  // Registers may only change while nothing is in flight, so the sender stops,
  // every queued reading is collected, and the block gets a latency's worth of
  // extra cycles before the next write.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [hcfm_pkg::CfgIdxW-1:0] idx,
                                input logic [hcfm_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_settings(input logic [hcfm_pkg::LevelW-1:0] mid,
                                input logic [hcfm_pkg::LevelW-1:0] hyst,
                                input logic [hcfm_pkg::RateW-1:0] rate);
    // Junk above the level fields must be ignored by the block.
    write_register(hcfm_pkg::CfgMid, {8'($urandom), mid});
    write_register(hcfm_pkg::CfgHyst, {8'($urandom), hyst});
    write_register(hcfm_pkg::CfgRate, rate);
  endtask

  // Random settings lean toward thresholds inside the ADC range, so that most
  // captures do find crossings, with the occasional extreme.
  task automatic pick_random_settings();
    logic [hcfm_pkg::LevelW-1:0] mid;
    logic [hcfm_pkg::LevelW-1:0] hyst;
    logic [hcfm_pkg::RateW-1:0]  rate;
    case ($urandom_range(0, 3))
      0:       mid = 16'($urandom);
      default: mid = 16'($urandom_range(200, 3900) * 16 + $urandom_range(0, 15));
    endcase
    case ($urandom_range(0, 4))
      0:       hyst = 16'($urandom);
      1:       hyst = '0;
      default: hyst = 16'($urandom_range(1, 400));
    endcase
    case ($urandom_range(0, 5))
      0:       rate = 24'($urandom);
      1:       rate = '1;
      2:       rate = 24'd1;
      default: rate = 24'($urandom_range(1000, 10000000));
    endcase
    write_settings(mid, hyst, rate);
  endtask

  // One capture shaped around the current midpoint: square, ramp and triangle
  // waves of random period and amplitude make well-formed crossing sequences;
  // white noise and glitches on a flat line make the broken ones. Some captures
  // hold a single sample.
  task automatic send_wave_capture(input int max_len);
    int len;
    int period;
    int half;
    int amp;
    int noise;
    int center;
    int shape;
    int offset;
    int ph;
    int v;
    shape  = $urandom_range(0, 9);
    len    = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, max_len);
    period = $urandom_range(2, 24);
    half   = period / 2;
    amp    = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 2100) : $urandom_range(1, 12);
    noise  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
    center = int'(sb.mid_q4 >> 4);
    offset = $urandom_range(0, period - 1);
    v      = center;
    for (int t = 0; t < len; t++) begin
      ph = (t + offset) % period;
      case (shape)
        0, 1, 2: v = (ph < half) ? center - amp : center + amp;
        3, 4, 5: v = center - amp + (2 * amp * ph) / (period - 1);
        6, 7:    v = center - amp + (4 * amp * ((ph < half) ? ph : period - ph)) / period;
        8:       v = $urandom_range(0, 4095);
        default: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4095) : center;
      endcase
      if (noise != 0) begin
        v = v + int'($urandom_range(0, 2 * noise)) - noise;
      end
      if (v < 0) begin
        v = 0;
      end
      if (v > 4095) begin
        v = 4095;
      end
      send_sample(hcfm_pkg::SampleBits'(v), t == len - 1);
    end
  endtask

  initial begin
    int burst[$];
    int phase;
    int start_items;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = hcfm_pkg::CfgMid;
    cfg_data_i  = '0;
    idle_on     = 1'b0;
    rx_hold_len = 0;
    items_sent  = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: thresholds at 2044 and 2052 LSB.
    // A capture of one sample has no pair to compare.
    burst = '{100};
    send_burst(burst);
    // Full-scale square wave, the last sample itself completing the third crossing.
    burst = '{0, 4095, 0, 4095, 0, 4095};
    send_burst(burst);
    // The new sample lands exactly on the upper threshold.
    burst = '{2040, 2052, 2040, 2052};
    send_burst(burst);
    // A single crossing cannot give a period.
    burst = '{0, 4095};
    send_burst(burst);
    settle();

    // A write to the unused index must change nothing.
    write_register(CfgUnused, '1);

    // Zero sample rate still gives a valid reading, with zero frequency.
    burst = '{0, 4095, 0, 4095};
    write_register(hcfm_pkg::CfgRate, '0);
    send_burst(burst);
    settle();
    // Lower threshold below zero: the detector can never arm.
    write_register(hcfm_pkg::CfgMid, '0);
    write_register(hcfm_pkg::CfgHyst, 24'd1);
    send_burst(burst);
    settle();
    // Upper threshold above sixteen times full scale: no crossing is possible.
    write_register(hcfm_pkg::CfgMid, '1);
    write_register(hcfm_pkg::CfgHyst, '1);
    send_burst(burst);

    // Random phases, each under its own settings. The first few use fixed settings,
    // mostly at the register extremes; the rest are random.
    phase = 0;
    start_items = items_sent;
    while (items_sent - start_items < RandomItems) begin
      settle();
      case (phase)
        0:       write_settings(16'd32768, '0, 24'd1);
        1:       write_settings('0, '1, '1);
        2:       write_settings('1, '0, 24'd10000000);
        3:       write_settings(16'd16000, '1, 24'd48000);
        4:       write_settings(16'd65520, '0, '1);
        default: pick_random_settings();
      endcase
      idle_on = (items_sent - start_items < QuietTail) && ($urandom_range(0, 3) != 0);
      if (phase == 6) begin
        // The receiver holds off while short captures keep coming, so the
        // result register fills, the next result waits behind it and the
        // block has to stall its sample input.
        idle_on = 1'b0;
        rx_hold_len = LongHold;
        repeat (6) send_wave_capture(6);
      end
      repeat (8) send_wave_capture(40);
      phase++;
    end

    idle_on = 1'b0;
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
